/* sv/lsb_stego_extractor_assert.svh */
// Assertion macros shared by the LSB steganography extractor.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef LSB_STEGO_EXTRACTOR_ASSERT_SVH
`define LSB_STEGO_EXTRACTOR_ASSERT_SVH

`define LSBSE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsb_stego_extractor: same-cycle check failed");

`define LSBSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsb_stego_extractor: next-cycle check failed");

`endif

/* sv/lsbse_pkg.sv */
// Package for the LSB steganography extractor: item types, status codes,
// phase codes, register indexes and register reset values. No dependencies.
`timescale 1ns / 1ps

package lsbse_pkg;

  localparam int MARKER_W = 40;
  localparam int MARKER_EXT_W = 64;
  localparam int SKIP_W = 10;
  localparam int MAXLEN_W = 8;
  localparam int COUNT_W = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_PIXELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd3;

  localparam logic [SKIP_W-1:0] SKIP_RESET = 10'd39;
  localparam logic [MARKER_W-1:0] START_RESET = 40'd336337256770;
  localparam logic [MARKER_W-1:0] END_RESET = 40'd340716507718;
  localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 8'd140;

  localparam logic [2:0] ST_CHAR = 3'd0;
  localparam logic [2:0] ST_END = 3'd1;
  localparam logic [2:0] ST_NO_START = 3'd2;
  localparam logic [2:0] ST_NO_END = 3'd3;
  localparam logic [2:0] ST_TOO_LONG = 3'd4;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_MESSAGE = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  typedef struct packed {
    logic [7:0] blue_byte;
    logic       first_pixel;
    logic       last_pixel;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] character;
    logic [2:0] status;
  } result_t;

endpackage

/* sv/lsbse_in_reg.sv */
// Input register of the LSB steganography extractor.
// Holds one accepted item until the core consumes it. Uses lsbse_pkg.
`timescale 1ns / 1ps

module lsbse_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lsbse_pkg::item_t    in_item,
  input  logic                advance,
  output logic                item_valid,
  output lsbse_pkg::item_t    item
);
  import lsbse_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  accept;

  assign in_stall = valid_r && !advance;
  assign accept = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item = item_r;

endmodule

/* sv/lsbse_core.sv */
// Extraction core: configuration registers, bit assembly, header check,
// end-marker delay window and status decisions. Uses lsbse_pkg.
`timescale 1ns / 1ps

module lsbse_core #(
  parameter int MARKER_BYTES = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lsbse_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lsbse_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  lsbse_pkg::item_t                    item,
  input  logic                                advance,
  output lsbse_pkg::result_t                  result
);
  import lsbse_pkg::*;

  localparam int WIN_DEPTH = (MARKER_BYTES > 1) ? MARKER_BYTES - 1 : 1;
  localparam logic [COUNT_W-1:0] MB_N = COUNT_W'(MARKER_BYTES);
  localparam logic [COUNT_W-1:0] MB_LESS1_N = COUNT_W'(MARKER_BYTES - 1);

  logic [SKIP_W-1:0]   skip_r;
  logic [MARKER_W-1:0] start_r;
  logic [MARKER_W-1:0] end_r;
  logic [MAXLEN_W-1:0] maxlen_r;

  logic [SKIP_W-1:0]  pc_r, pc_nxt, pc_eff;
  logic [2:0]         bp_r, bp_nxt, bp_eff;
  logic [7:0]         asm_r, asm_nxt, asm_eff;
  logic [COUNT_W-1:0] bc_r, bc_nxt, bc_eff;
  logic [1:0]         ph_r, ph_nxt, ph_eff;
  logic               bad_r, bad_nxt, bad_eff;
  logic [7:0]         win_r [WIN_DEPTH];
  logic [7:0]         win_nxt [WIN_DEPTH];
  logic [7:0]         win_eff [WIN_DEPTH];

  logic [MARKER_EXT_W-1:0] start_ext;
  logic [MARKER_EXT_W-1:0] end_ext;
  logic [7:0]              asm_new;
  logic [COUNT_W-1:0]      bc_inc;
  logic [COUNT_W-1:0]      excess;
  logic                    bad_new;
  logic                    match;
  logic [7:0]              leaving;

  assign start_ext = {{(MARKER_EXT_W - MARKER_W){1'b0}}, start_r};
  assign end_ext = {{(MARKER_EXT_W - MARKER_W){1'b0}}, end_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= SKIP_RESET;
      start_r <= START_RESET;
      end_r <= END_RESET;
      maxlen_r <= MAXLEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SKIP_PIXELS: skip_r <= cfg_wdata[SKIP_W-1:0];
        CFG_START_MARKER: start_r <= cfg_wdata[MARKER_W-1:0];
        CFG_END_MARKER: end_r <= cfg_wdata[MARKER_W-1:0];
        CFG_MAX_LENGTH: maxlen_r <= cfg_wdata[MAXLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pc_eff = item.first_pixel ? '0 : pc_r;
    bp_eff = item.first_pixel ? '0 : bp_r;
    asm_eff = item.first_pixel ? '0 : asm_r;
    bc_eff = item.first_pixel ? '0 : bc_r;
    ph_eff = item.first_pixel ? PH_HEADER : ph_r;
    bad_eff = item.first_pixel ? 1'b0 : bad_r;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      win_eff[i] = item.first_pixel ? 8'd0 : win_r[i];
    end
  end

  always_comb begin
    pc_nxt = pc_eff;
    bp_nxt = bp_eff;
    asm_nxt = asm_eff;
    bc_nxt = bc_eff;
    ph_nxt = ph_eff;
    bad_nxt = bad_eff;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      win_nxt[i] = win_eff[i];
    end
    asm_new = asm_eff;
    asm_new[bp_eff] = item.blue_byte[0];
    bc_inc = bc_eff + 1'b1;
    excess = bc_inc - MB_N;
    bad_new = bad_eff | (asm_new != start_ext[{bc_eff[2:0], 3'b000} +: 8]);
    match = (asm_new == end_ext[8*(MARKER_BYTES-1) +: 8]);
    for (int i = 0; i < MARKER_BYTES - 1; i++) begin
      if (win_eff[i] != end_ext[8*i +: 8]) begin
        match = 1'b0;
      end
    end
    leaving = (MARKER_BYTES > 1) ? win_eff[0] : asm_new;
    result.valid = 1'b0;
    result.character = 8'd0;
    result.status = ST_CHAR;

    if (ph_eff != PH_DONE) begin
      if (ph_eff == PH_HEADER && pc_eff < skip_r) begin
        pc_nxt = pc_eff + 1'b1;
      end else begin
        asm_nxt = asm_new;
        if (bp_eff == 3'd7) begin
          bp_nxt = 3'd0;
          if (ph_eff == PH_HEADER) begin
            bad_nxt = bad_new;
            if (bc_inc >= MB_N) begin
              bc_nxt = '0;
              if (bad_new) begin
                ph_nxt = PH_DONE;
                result.valid = 1'b1;
                result.status = ST_NO_START;
              end else begin
                ph_nxt = PH_MESSAGE;
              end
            end else begin
              bc_nxt = bc_inc;
            end
          end else begin
            bc_nxt = bc_inc;
            if (bc_inc >= MB_N && match) begin
              ph_nxt = PH_DONE;
              result.valid = 1'b1;
              result.status = (excess > {1'b0, maxlen_r}) ? ST_TOO_LONG : ST_END;
            end else if (bc_inc >= MB_N && (bc_inc - MB_LESS1_N) > {1'b0, maxlen_r}) begin
              ph_nxt = PH_DONE;
              result.valid = 1'b1;
              result.status = ST_TOO_LONG;
            end else begin
              if (bc_inc >= MB_N) begin
                result.valid = 1'b1;
                result.status = ST_CHAR;
                result.character = leaving;
              end
              for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                win_nxt[i] = win_eff[i+1];
              end
              if (MARKER_BYTES > 1) begin
                win_nxt[WIN_DEPTH-1] = asm_new;
              end
            end
          end
        end else begin
          bp_nxt = bp_eff + 1'b1;
        end
      end

      if (item.last_pixel && ph_nxt != PH_DONE) begin
        result.valid = 1'b1;
        result.character = 8'd0;
        result.status = (ph_nxt == PH_HEADER) ? ST_NO_START : ST_NO_END;
        ph_nxt = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
      bp_r <= '0;
      asm_r <= '0;
      bc_r <= '0;
      ph_r <= PH_HEADER;
      bad_r <= 1'b0;
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_r[i] <= 8'd0;
      end
    end else if (advance) begin
      pc_r <= pc_nxt;
      bp_r <= bp_nxt;
      asm_r <= asm_nxt;
      bc_r <= bc_nxt;
      ph_r <= ph_nxt;
      bad_r <= bad_nxt;
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

endmodule

/* sv/lsbse_out_reg.sv */
// Result register of the LSB steganography extractor.
// Holds one result until the receiver takes it. Uses lsbse_pkg.
`timescale 1ns / 1ps

module lsbse_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  lsbse_pkg::result_t   result,
  output logic                 ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_character,
  output logic [2:0]           out_status
);
  import lsbse_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] char_r;
  logic [2:0] status_r;
  logic       load;

  assign ready = !valid_r || !out_stall;
  assign load = advance && result.valid;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= result.character;
      status_r <= result.status;
    end
  end

  assign out_valid = valid_r;
  assign out_character = char_r;
  assign out_status = status_r;

endmodule

/* sv/lsb_stego_extractor.sv */
// Recovers a text message hidden in the blue LSBs of a pixel stream. One pixel
// item is taken every clock unless input stalls; a pixel is held in the input
// register and its result in the result register. Input stalls only while a
// finished result waits in the result register and the receiver stalls it.
`timescale 1ns / 1ps

module lsb_stego_extractor #(
  parameter int MARKER_BYTES = 5
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lsbse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsbse_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_blue_byte,
  input  logic                             in_first_pixel,
  input  logic                             in_last_pixel,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_character,
  output logic [2:0]                       out_status
);
  import lsbse_pkg::*;

  `include "lsb_stego_extractor_assert.svh"

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    ready;
  logic    advance;
  result_t result;

  assign in_item.blue_byte = in_blue_byte;
  assign in_item.first_pixel = in_first_pixel;
  assign in_item.last_pixel = in_last_pixel;
  assign advance = item_valid && ready;

  lsbse_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  lsbse_core #(
    .MARKER_BYTES (MARKER_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .item      (item),
    .advance   (advance),
    .result    (result)
  );

  lsbse_out_reg u_out_reg (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (advance),
    .result        (result),
    .ready         (ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_status    (out_status)
  );

  `LSBSE_ASSERT_SAME(a_stall_only_when_blocked, in_stall, out_valid && out_stall)
  `LSBSE_ASSERT_SAME(a_status_clears_char, out_valid && out_status != ST_CHAR,
                     out_character == 8'd0)
  `LSBSE_ASSERT_NEXT(a_accept_fills_input, in_valid && !in_stall, item_valid)

endmodule
